@@ sv/cmfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared types and face codes for the cube map face and uv select unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfs_pkg;

  localparam int FACE_W = 3;

  typedef logic [FACE_W-1:0] face_t;

  // face codes in selection priority order
  localparam face_t FACE_POS_Z = 3'd0;
  localparam face_t FACE_NEG_Z = 3'd1;
  localparam face_t FACE_NEG_X = 3'd2;
  localparam face_t FACE_POS_X = 3'd3;
  localparam face_t FACE_POS_Y = 3'd4;
  localparam face_t FACE_NEG_Y = 3'd5;

  // side-band status that rides along the divider stages
  typedef struct packed {
    face_t face;
    logic  zero;
    logic  sat_u;
    logic  sat_v;
  } side_t;

endpackage

`default_nettype wire

@@ sv/cmfs_dir_if.sv @@
// ----------------------------------------------------------------------------
// cmfs_dir_if
// Valid/ready channel carrying one signed direction request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmfs_dir_if #(
  parameter int COMP_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] dir_x;
  logic signed [COMP_WIDTH-1:0] dir_y;
  logic signed [COMP_WIDTH-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

`default_nettype wire

@@ sv/cmfs_res_if.sv @@
// ----------------------------------------------------------------------------
// cmfs_res_if
// Valid/ready channel carrying one face and uv result request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmfs_res_if #(
  parameter int UV_FRAC_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              face_index;
  logic [UV_FRAC_BITS-1:0] tex_u;
  logic [UV_FRAC_BITS-1:0] tex_v;
  logic                    zero_direction;

  modport source (output valid, output face_index, output tex_u, output tex_v,
                  output zero_direction, input ready);
  modport sink   (input valid, input face_index, input tex_u, input tex_v,
                  input zero_direction, output ready);
endinterface

`default_nettype wire

@@ sv/cmfs_select.sv @@
// ----------------------------------------------------------------------------
// cmfs_select
// Two pipeline stages: major axis and face pick, then divider operand setup.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfs_select
  import cmfs_pkg::*;
#(
  parameter int COMP_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         en_a,
  input  wire logic                         en_b,
  input  wire logic signed [COMP_WIDTH-1:0] dir_x,
  input  wire logic signed [COMP_WIDTH-1:0] dir_y,
  input  wire logic signed [COMP_WIDTH-1:0] dir_z,
  output logic                              vld_a,
  output logic                              vld_b,
  output logic [COMP_WIDTH:0]               rem_u,
  output logic [COMP_WIDTH:0]               rem_v,
  output logic [COMP_WIDTH:0]               den,
  output side_t                             side
);

  localparam int CW = COMP_WIDTH;
  localparam int NW = COMP_WIDTH + 1;

  logic [CW-1:0]        ax, ay, az;
  logic                 z_major, x_major;
  logic signed [NW-1:0] xe, ye, ze;
  face_t                face_next;
  logic [CW-1:0]        m_next;
  logic signed [NW-1:0] nu_next, nv_next;
  logic                 zero_next;

  face_t                a_face;
  logic                 a_zero;
  logic [CW-1:0]        a_m;
  logic signed [NW-1:0] a_nu, a_nv;

  logic [NW-1:0]        sum_u, sum_v;
  logic                 sat_u_next, sat_v_next;

  // magnitudes, the most negative value maps to 2^(CW-1) unsigned
  always_comb begin
    ax = dir_x[CW-1] ? (~dir_x + 1'b1) : dir_x;
    ay = dir_y[CW-1] ? (~dir_y + 1'b1) : dir_y;
    az = dir_z[CW-1] ? (~dir_z + 1'b1) : dir_z;
    xe = {dir_x[CW-1], dir_x};
    ye = {dir_y[CW-1], dir_y};
    ze = {dir_z[CW-1], dir_z};
  end

  // face pick, ties favor z over x over y, and positive z / negative x first
  always_comb begin
    z_major   = (az >= ax) && (az >= ay);
    x_major   = !z_major && (ax >= ay);
    zero_next = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    if (z_major) begin
      m_next = az;
      face_next = (!dir_z[CW-1] && (dir_z != '0)) ? FACE_POS_Z : FACE_NEG_Z;
    end else if (x_major) begin
      m_next = ax;
      face_next = dir_x[CW-1] ? FACE_NEG_X : FACE_POS_X;
    end else begin
      m_next = ay;
      face_next = (!dir_y[CW-1] && (dir_y != '0)) ? FACE_POS_Y : FACE_NEG_Y;
    end
    case (face_next)
      FACE_POS_Z: begin nu_next = xe;  nv_next = -ye; end
      FACE_NEG_Z: begin nu_next = -xe; nv_next = -ye; end
      FACE_NEG_X: begin nu_next = ze;  nv_next = -ye; end
      FACE_POS_X: begin nu_next = -ze; nv_next = -ye; end
      FACE_POS_Y: begin nu_next = xe;  nv_next = ze;  end
      default:    begin nu_next = xe;  nv_next = -ze; end
    endcase
  end

  // stage a valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en_a) begin
      vld_a <= in_valid;
    end
  end

  // stage a payload
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_face <= face_next;
      a_zero <= zero_next;
      a_m    <= m_next;
      a_nu   <= nu_next;
      a_nv   <= nv_next;
    end
  end

  // numerator n + m lies in [0, 2m], a full ratio of one saturates
  always_comb begin
    sum_u      = a_nu + {1'b0, a_m};
    sum_v      = a_nv + {1'b0, a_m};
    sat_u_next = (a_nu == {1'b0, a_m});
    sat_v_next = (a_nv == {1'b0, a_m});
  end

  // stage b valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= 1'b0;
    end else if (en_b) begin
      vld_b <= vld_a;
    end
  end

  // stage b payload
  always_ff @(posedge clk) begin
    if (en_b) begin
      rem_u      <= sat_u_next ? '0 : sum_u;
      rem_v      <= sat_v_next ? '0 : sum_v;
      den        <= {a_m, 1'b0};
      side.face  <= a_face;
      side.zero  <= a_zero;
      side.sat_u <= sat_u_next;
      side.sat_v <= sat_v_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/cmfs_div_step.sv @@
// ----------------------------------------------------------------------------
// cmfs_div_step
// One registered restoring division step producing a quotient bit for u and v.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfs_div_step
  import cmfs_pkg::*;
#(
  parameter int COMP_WIDTH   = 16,
  parameter int UV_FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic                    en,
  input  wire logic [COMP_WIDTH:0]     rem_u_in,
  input  wire logic [COMP_WIDTH:0]     rem_v_in,
  input  wire logic [UV_FRAC_BITS-1:0] quo_u_in,
  input  wire logic [UV_FRAC_BITS-1:0] quo_v_in,
  input  wire logic [COMP_WIDTH:0]     den_in,
  input  wire side_t                   side_in,
  output logic                         vld,
  output logic [COMP_WIDTH:0]          rem_u,
  output logic [COMP_WIDTH:0]          rem_v,
  output logic [UV_FRAC_BITS-1:0]      quo_u,
  output logic [UV_FRAC_BITS-1:0]      quo_v,
  output logic [COMP_WIDTH:0]          den,
  output side_t                        side
);

  localparam int NW = COMP_WIDTH + 1;
  localparam int QW = UV_FRAC_BITS;

  logic [NW:0]   tu, tv, du, dv;
  logic          ge_u, ge_v;
  logic [NW-1:0] rem_u_next, rem_v_next;

  // shift remainder, compare against divisor, subtract when it fits
  always_comb begin
    tu         = {rem_u_in, 1'b0};
    tv         = {rem_v_in, 1'b0};
    du         = tu - {1'b0, den_in};
    dv         = tv - {1'b0, den_in};
    ge_u       = tu >= {1'b0, den_in};
    ge_v       = tv >= {1'b0, den_in};
    rem_u_next = ge_u ? du[NW-1:0] : tu[NW-1:0];
    rem_v_next = ge_v ? dv[NW-1:0] : tv[NW-1:0];
  end

  // valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_u <= rem_u_next;
      rem_v <= rem_v_next;
      quo_u <= {quo_u_in[QW-2:0], ge_u};
      quo_v <= {quo_v_in[QW-2:0], ge_v};
      den   <= den_in;
      side  <= side_in;
    end
  end

endmodule

`default_nettype wire

@@ sv/cube_map_face_uv_select_unit.sv @@
// ----------------------------------------------------------------------------
// cube_map_face_uv_select_unit
// Picks the cube map face of a direction and its u, v face coordinates.
// ----------------------------------------------------------------------------
// usage
//   dir  : sink channel, one signed direction (dir_x, dir_y, dir_z) per request
//   res  : source channel, face_index, tex_u, tex_v and zero_direction
//   throughput: one request per cycle, every cycle, as long as res is drained
//   stages from accept to res.valid, in order:
//     one stage picks the major axis and face, one forms the divider operands,
//     UV_FRAC_BITS stages each produce one quotient bit of u and of v, and a
//     final output register applies saturation and the zero direction case
//   every stage carries its own valid bit and holds only when the stage
//   after it is full and held, so empty slots are filled even while a
//   result waits on res; dir.ready drops only once the whole pipe is full
//   and res.ready is low, and no request is lost or repeated on a stall
//   reset (rst, synchronous) clears every valid bit; only payload data survives
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_face_uv_select_unit
  import cmfs_pkg::*;
#(
  parameter int COMP_WIDTH   = 16,
  parameter int UV_FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  cmfs_dir_if.sink dir,
  cmfs_res_if.source res
);

  localparam int NW       = COMP_WIDTH + 1;
  localparam int QW       = UV_FRAC_BITS;
  localparam int NSTG     = UV_FRAC_BITS + 3;
  localparam int STG_OUT  = NSTG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  logic [NW-1:0] rem_u [QW+1];
  logic [NW-1:0] rem_v [QW+1];
  logic [NW-1:0] den   [QW+1];
  logic [QW-1:0] quo_u [QW+1];
  logic [QW-1:0] quo_v [QW+1];
  side_t         side  [QW+1];

  logic          out_vld;
  face_t         out_face;
  logic [QW-1:0] out_u;
  logic [QW-1:0] out_v;
  logic          out_zero;

  // stall chain, a stage moves when it is empty or the next one moves
  assign en[STG_OUT] = !vld[STG_OUT] || res.ready;
  for (genvar k = 0; k < STG_OUT; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign dir.ready = en[0];

  // face pick and operand setup
  cmfs_select #(
    .COMP_WIDTH(COMP_WIDTH)
  ) u_select (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dir.valid),
    .en_a     (en[0]),
    .en_b     (en[1]),
    .dir_x    (dir.dir_x),
    .dir_y    (dir.dir_y),
    .dir_z    (dir.dir_z),
    .vld_a    (vld[0]),
    .vld_b    (vld[1]),
    .rem_u    (rem_u[0]),
    .rem_v    (rem_v[0]),
    .den      (den[0]),
    .side     (side[0])
  );

  assign quo_u[0] = '0;
  assign quo_v[0] = '0;

  // divider, one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    cmfs_div_step #(
      .COMP_WIDTH   (COMP_WIDTH),
      .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld[i+1]),
      .en       (en[i+2]),
      .rem_u_in (rem_u[i]),
      .rem_v_in (rem_v[i]),
      .quo_u_in (quo_u[i]),
      .quo_v_in (quo_v[i]),
      .den_in   (den[i]),
      .side_in  (side[i]),
      .vld      (vld[i+2]),
      .rem_u    (rem_u[i+1]),
      .rem_v    (rem_v[i+1]),
      .quo_u    (quo_u[i+1]),
      .quo_v    (quo_v[i+1]),
      .den      (den[i+1]),
      .side     (side[i+1])
    );
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en[STG_OUT]) begin
      out_vld <= vld[STG_OUT-1];
    end
  end

  assign vld[STG_OUT] = out_vld;

  // output register payload, saturation and zero direction override
  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      out_zero <= side[QW].zero;
      if (side[QW].zero) begin
        out_face <= FACE_POS_Z;
        out_u    <= '0;
        out_v    <= '0;
      end else begin
        out_face <= side[QW].face;
        out_u    <= side[QW].sat_u ? '1 : quo_u[QW];
        out_v    <= side[QW].sat_v ? '1 : quo_v[QW];
      end
    end
  end

  assign res.valid          = out_vld;
  assign res.face_index     = out_face;
  assign res.tex_u          = out_u;
  assign res.tex_v          = out_v;
  assign res.zero_direction = out_zero;

endmodule

`default_nettype wire

@@ sv/cmfs_checker.sv @@
// ----------------------------------------------------------------------------
// cmfs_checker
// Port-level checks for the cube map face and uv select unit, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfs_checker
  import cmfs_pkg::*;
#(
  parameter int UV_FRAC_BITS = 16
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [2:0]              face_index,
  input wire logic [UV_FRAC_BITS-1:0] tex_u,
  input wire logic [UV_FRAC_BITS-1:0] tex_v,
  input wire logic                    zero_direction
);

  // no result shows right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // an empty output register never blocks a new request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  // zero direction forces face and coordinates to zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_direction) |-> (face_index == FACE_POS_Z) &&
                                      (tex_u == '0) && (tex_v == '0))
    else $error("zero direction with nonzero face or coordinates");

  // a stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(face_index) &&
      $stable(tex_u) && $stable(tex_v) && $stable(zero_direction))
    else $error("stalled result changed or dropped");

endmodule

bind cube_map_face_uv_select_unit cmfs_checker #(
  .UV_FRAC_BITS (UV_FRAC_BITS)
) u_cmfs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (dir.ready),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .face_index     (res.face_index),
  .tex_u          (res.tex_u),
  .tex_v          (res.tex_v),
  .zero_direction (res.zero_direction)
);

`default_nettype wire

@@ dv/cube_map_face_uv_select_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_face_uv_select_unit_tb
// Streams signed directions through the face and uv select unit. Expected
// face, u, v and zero flag are computed by an exact integer predictor and
// compared in order against every result. The sender idles in bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module cube_map_face_uv_select_unit_tb;
  import cmfs_pkg::*;

  localparam int COMP_W     = 16;
  localparam int UV_W       = 16;
  localparam int LATENCY    = UV_W + 3;
  localparam int N_RANDOM   = 1400;
  localparam int MAX_CYCLES = 200000;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    face_t         face;
    logic [UV_W-1:0] tex_u;
    logic [UV_W-1:0] tex_v;
    logic          zero;
  } face_uv_t;

  // in-order store of expected face and uv results
  class uv_scoreboard;
    face_uv_t expected_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // (n + m) / 2m as unsigned fixed point, saturated below 1.0
    function longint face_coord(longint n, longint m);
      longint q;
      q = ((n + m) << UV_W) / (2 * m);
      if (q > (64'sd1 << UV_W) - 1)
        q = (64'sd1 << UV_W) - 1;
      return q;
    endfunction

    // predict face and uv for an accepted direction
    function void note_direction(comp_t x, comp_t y, comp_t z);
      longint   sx, sy, sz, m, nu, nv;
      longint   dots[6];
      face_t    face;
      face_uv_t e;
      sx = x;
      sy = y;
      sz = z;
      if (sx == 0 && sy == 0 && sz == 0) begin
        e = '{face: FACE_POS_Z, tex_u: '0, tex_v: '0, zero: 1'b1};
      end else begin
        dots[0] = sz;
        dots[1] = -sz;
        dots[2] = -sx;
        dots[3] = sx;
        dots[4] = sy;
        dots[5] = -sy;
        // strict compare keeps the lower face on a tie
        m = dots[0];
        face = FACE_POS_Z;
        for (int i = 1; i < 6; i++) begin
          if (dots[i] > m) begin
            m = dots[i];
            face = face_t'(i);
          end
        end
        case (face)
          FACE_POS_Z: begin nu = sx;  nv = -sy; end
          FACE_NEG_Z: begin nu = -sx; nv = -sy; end
          FACE_NEG_X: begin nu = sz;  nv = -sy; end
          FACE_POS_X: begin nu = -sz; nv = -sy; end
          FACE_POS_Y: begin nu = sx;  nv = sz;  end
          default:    begin nu = sx;  nv = -sz; end
        endcase
        e.face  = face;
        e.tex_u = UV_W'(face_coord(nu, m));
        e.tex_v = UV_W'(face_coord(nv, m));
        e.zero  = 1'b0;
      end
      expected_q.push_back(e);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(face_uv_t got);
      face_uv_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: face %0d u %0d v %0d zero %0b",
               got.face, got.tex_u, got.tex_v, got.zero);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.face !== e.face) begin
        $error("face_index: expected %0d, got %0d", e.face, got.face);
        errors++;
      end
      if (got.tex_u !== e.tex_u) begin
        $error("tex_u: expected %0d, got %0d", e.tex_u, got.tex_u);
        errors++;
      end
      if (got.tex_v !== e.tex_v) begin
        $error("tex_v: expected %0d, got %0d", e.tex_v, got.tex_v);
        errors++;
      end
      if (got.zero !== e.zero) begin
        $error("zero_direction: expected %0b, got %0b", e.zero, got.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles = 0;

  uv_scoreboard sb = new();

  cmfs_dir_if #(.COMP_WIDTH(COMP_W))   dir_ch ();
  cmfs_res_if #(.UV_FRAC_BITS(UV_W))   res_ch ();

  cube_map_face_uv_select_unit #(
    .COMP_WIDTH   (COMP_W),
    .UV_FRAC_BITS (UV_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .dir (dir_ch.sink),
    .res (res_ch.source)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // note every accepted request
  always @(posedge clk) begin
    if (!rst && dir_ch.valid && dir_ch.ready)
      sb.note_direction(dir_ch.dir_x, dir_ch.dir_y, dir_ch.dir_z);
  end

  // check every accepted result
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result('{face: res_ch.face_index, tex_u: res_ch.tex_u,
                        tex_v: res_ch.tex_v, zero: res_ch.zero_direction});
  end

  // receiver: modes of always ready, random stalls and heavy stalls
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= ($urandom_range(0, 1) == 1);
        2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // one request, held until accepted
  task automatic send_direction(input comp_t x, input comp_t y, input comp_t z);
    dir_ch.valid <= 1'b1;
    dir_ch.dir_x <= x;
    dir_ch.dir_y <= y;
    dir_ch.dir_z <= z;
    @(posedge clk);
    while (!dir_ch.ready) @(posedge clk);
  endtask

  // one request from integer literals
  task automatic send_literal(input int x, input int y, input int z);
    send_direction(comp_t'(x), comp_t'(y), comp_t'(z));
  endtask

  // drop valid and wait until every result is back
  task automatic drain_results();
    dir_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic comp_t pick_extreme();
    case ($urandom_range(0, 5))
      0:       return comp_t'(-32768);
      1:       return comp_t'(-32767);
      2:       return comp_t'(-1);
      3:       return comp_t'(0);
      4:       return comp_t'(1);
      default: return comp_t'(32767);
    endcase
  endfunction

  // random direction, shaped toward ties, saturation and extremes
  task automatic send_random_direction();
    comp_t x, y, z, a;
    int    k;
    a = comp_t'($urandom_range(1, 32767));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = comp_t'($urandom);
        y = comp_t'($urandom);
        z = comp_t'($urandom);
      end
      4: begin
        x = comp_t'($urandom_range(0, 8)) - comp_t'(4);
        y = comp_t'($urandom_range(0, 8)) - comp_t'(4);
        z = comp_t'($urandom_range(0, 8)) - comp_t'(4);
      end
      5: begin
        // equal magnitudes give face ties and ratios of exactly one
        x = $urandom_range(0, 1) ? a : -a;
        y = $urandom_range(0, 1) ? a : -a;
        z = $urandom_range(0, 2) == 0 ? comp_t'($urandom_range(0, a)) :
            ($urandom_range(0, 1) ? a : -a);
      end
      6: begin
        x = pick_extreme();
        y = pick_extreme();
        z = pick_extreme();
      end
      7: begin
        // one major axis, one minor with a ratio near plus or minus one to it
        x = $urandom_range(0, 1) ? a : -a;
        y = comp_t'($urandom_range(0, 1) ? (a - $urandom_range(0, 2)) :
                                            -(a - $urandom_range(0, 2)));
        z = comp_t'($urandom_range(0, a)) - comp_t'($urandom_range(0, a));
        case ($urandom_range(0, 2))
          0: begin a = x; x = z; z = a; end
          1: begin a = x; x = y; y = a; end
          default: ;
        endcase
      end
      8: begin
        x = '0;
        y = '0;
        z = '0;
        case ($urandom_range(0, 3))
          0: x = comp_t'($urandom);
          1: y = comp_t'($urandom);
          2: z = comp_t'($urandom);
          default: ;
        endcase
      end
      default: begin
        // scaled small direction, result should not depend on scale
        k = $urandom_range(1, 4000);
        x = comp_t'(($urandom_range(0, 16) - 8) * k);
        y = comp_t'(($urandom_range(0, 16) - 8) * k);
        z = comp_t'(($urandom_range(0, 16) - 8) * k);
      end
    endcase
    send_direction(x, y, z);
  endtask

  // stimulus
  initial begin
    int burst_left;
    int gap;
    rst <= 1'b1;
    dir_ch.valid <= 1'b0;
    dir_ch.dir_x <= '0;
    dir_ch.dir_y <= '0;
    dir_ch.dir_z <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, each face, extremes, ties, saturation
    send_literal(0, 0, 0);
    send_literal(0, 0, 5);
    send_literal(0, 0, -5);
    send_literal(-5, 0, 0);
    send_literal(5, 0, 0);
    send_literal(0, 5, 0);
    send_literal(0, -5, 0);
    send_literal(100, 100, 100);
    send_literal(-100, -100, -100);
    send_literal(-32768, 0, 0);
    send_literal(-32768, -32768, -32768);
    send_literal(32767, 32767, 32767);
    send_literal(-32768, 32767, 0);
    send_literal(32767, -32768, 12345);
    send_literal(5, 5, 0);
    send_literal(0, -7, -7);
    send_literal(-1, 1, 0);
    send_literal(1, -1, 0);
    send_literal(0, 1, -1);
    send_literal(32767, 0, -32767);
    send_literal(-1, -1, 1);
    send_literal(0, 0, 0);
    send_literal(-32768, -32768, 32767);
    send_literal(3, -2, 1);
    drain_results();

    // random bursts with random gaps
    burst_left = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2)
        drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          dir_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_random_direction();
    end

    // end of run
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
